@@ rtl/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared widths, reset values, sector codes and fixed-point constants for the
// six-sector space vector pwm duty calculator
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VOLT_W        = 16;
  localparam int PERIOD_W      = 16;
  localparam int SECTOR_W      = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd999;

  // sqrt(3) with 30 fraction bits
  localparam logic [63:0] SQ3_Q30 = 64'd1859775393;

  typedef logic [SECTOR_W-1:0] sector_t;

  localparam sector_t SEC_NONE = 3'd0;
  localparam sector_t SEC_1    = 3'd1;
  localparam sector_t SEC_2    = 3'd2;
  localparam sector_t SEC_3    = 3'd3;
  localparam sector_t SEC_4    = 3'd4;
  localparam sector_t SEC_5    = 3'd5;
  localparam sector_t SEC_6    = 3'd6;

  // sqrt(3) rounded to frac fraction bits
  function automatic logic [63:0] sq3_const(input int frac);
    return (SQ3_Q30 + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  // sqrt(3)/2 rounded to frac fraction bits
  function automatic logic [63:0] sq3h_const(input int frac);
    return (SQ3_Q30 + (64'd1 << (30 - frac))) >> (31 - frac);
  endfunction

  // index bits: {y term negative, z term negative, x term positive}
  function automatic sector_t sector_lookup(input logic [2:0] idx);
    sector_t s;
    unique case (idx)
      3'd0:    s = SEC_NONE;
      3'd1:    s = SEC_2;
      3'd2:    s = SEC_6;
      3'd3:    s = SEC_1;
      3'd4:    s = SEC_4;
      3'd5:    s = SEC_3;
      3'd6:    s = SEC_5;
      default: s = SEC_NONE;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/svpwm_tcalc.sv @@
// ----------------------------------------------------------------------------
// svpwm_tcalc
// four-stage front end: products, x/y/z and sector, active times t1/t2,
// their sum, overmodulation flag and half zero-vector time
// ----------------------------------------------------------------------------
module svpwm_tcalc #(
  parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [svpwm_pkg::VOLT_W-1:0]   in_alpha,
  input  logic signed [svpwm_pkg::VOLT_W-1:0]   in_beta,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output svpwm_pkg::sector_t                    out_sec,
  output logic                                  out_over,
  output logic [FRAC_BITS-1:0]                  out_t0h,
  output logic [FRAC_BITS+1:0]                  out_t1,
  output logic [FRAC_BITS+1:0]                  out_t2,
  output logic [FRAC_BITS+2:0]                  out_sum
);
  import svpwm_pkg::*;

  localparam int XW = FRAC_BITS + 19;
  localparam int TW = FRAC_BITS + 2;
  localparam int SW = FRAC_BITS + 3;
  localparam int OW = FRAC_BITS + 1;
  localparam int NS = 4;

  localparam logic signed [XW-1:0] K_SQ3  = XW'(sq3_const(FRAC_BITS));
  localparam logic signed [XW-1:0] K_SQ3H = XW'(sq3h_const(FRAC_BITS));
  localparam logic signed [XW-1:0] K_3H   = XW'(64'd3 << (FRAC_BITS - 1));
  localparam logic [SW-1:0]        ONE    = SW'(64'd1 << FRAC_BITS);

  function automatic logic [TW-1:0] to_time(input logic signed [XW-1:0] v);
    logic [TW-1:0] t;
    if (v[XW-1] || (v == '0)) begin
      t = '0;
    end else begin
      t = v[15+TW-1:15];
    end
    return t;
  endfunction

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic signed [XW-1:0] a_ext, b_ext;
  logic signed [XW-1:0] pa_r, pb1_r, pb2_r;
  logic signed [XW-1:0] x_r, y_r, z_r;
  logic signed [XW-1:0] y_nxt, z_nxt;
  sector_t              sec1_r, sec2_r, sec3_r;
  logic signed [XW-1:0] s1_nxt, s2_nxt;
  logic [TW-1:0]        t1_r, t2_r, t1o_r, t2o_r;
  logic [SW-1:0]        sum_nxt, sum_r;
  logic [OW-1:0]        diff_nxt;
  logic                 over_nxt, over_r;
  logic [FRAC_BITS-1:0] t0h_r;

  assign rdy[NS-1] = !v_r[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign a_ext = XW'(in_alpha);
  assign b_ext = XW'(in_beta);

  assign y_nxt = pa_r + pb2_r;
  assign z_nxt = pb2_r - pa_r;

  always_comb begin
    s1_nxt = '0;
    s2_nxt = '0;
    unique case (sec1_r)
      SEC_1: begin
        s1_nxt = y_r;
        s2_nxt = x_r;
      end
      SEC_2: begin
        s1_nxt = -z_r;
        s2_nxt = y_r;
      end
      SEC_3: begin
        s1_nxt = x_r;
        s2_nxt = z_r;
      end
      SEC_4: begin
        s1_nxt = -y_r;
        s2_nxt = -x_r;
      end
      SEC_5: begin
        s1_nxt = z_r;
        s2_nxt = -y_r;
      end
      SEC_6: begin
        s1_nxt = -x_r;
        s2_nxt = -z_r;
      end
      default: begin
        s1_nxt = '0;
        s2_nxt = '0;
      end
    endcase
  end

  assign sum_nxt  = SW'(t1_r) + SW'(t2_r);
  assign over_nxt = sum_nxt > ONE;
  assign diff_nxt = ONE[OW-1:0] - sum_nxt[OW-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pa_r  <= a_ext * K_3H;
      pb1_r <= b_ext * K_SQ3;
      pb2_r <= b_ext * K_SQ3H;
    end
    if (rdy[1]) begin
      x_r    <= pb1_r;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      sec1_r <= sector_lookup({y_nxt[XW-1], z_nxt[XW-1],
                               !pb1_r[XW-1] && (pb1_r != '0)});
    end
    if (rdy[2]) begin
      t1_r   <= to_time(s1_nxt);
      t2_r   <= to_time(s2_nxt);
      sec2_r <= sec1_r;
    end
    if (rdy[3]) begin
      t1o_r  <= t1_r;
      t2o_r  <= t2_r;
      sum_r  <= sum_nxt;
      over_r <= over_nxt;
      t0h_r  <= over_nxt ? '0 : diff_nxt[OW-1:1];
      sec3_r <= sec2_r;
    end
  end

  assign out_sec  = sec3_r;
  assign out_over = over_r;
  assign out_t0h  = t0h_r;
  assign out_t1   = t1o_r;
  assign out_t2   = t2o_r;
  assign out_sum  = sum_r;

endmodule

@@ rtl/svpwm_div.sv @@
// ----------------------------------------------------------------------------
// svpwm_div
// two-lane pipelined restoring divider, one quotient bit per stage,
// q = floor(num * 2^FRAC_BITS / den) with a shared divisor and a side tag
// ----------------------------------------------------------------------------
module svpwm_div #(
  parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FRAC_BITS+1:0]  in_num1,
  input  logic [FRAC_BITS+1:0]  in_num2,
  input  logic [FRAC_BITS+2:0]  in_den,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS:0]    out_q1,
  output logic [FRAC_BITS:0]    out_q2,
  output logic [TAG_W-1:0]      out_tag
);
  import svpwm_pkg::*;

  localparam int TW    = FRAC_BITS + 2;
  localparam int SW    = FRAC_BITS + 3;
  localparam int QW    = FRAC_BITS + 1;
  localparam int NS    = QW;
  localparam int LANES = 2;

  logic [NS-1:0]    v_r;
  logic [NS-1:0]    rdy;
  logic [NS-1:0]    v_in;
  logic [TW-1:0]    num     [LANES];
  logic [SW-1:0]    rem_in  [NS][LANES];
  logic             bit_in  [NS][LANES];
  logic [QW-1:0]    q_in    [NS][LANES];
  logic [SW-1:0]    den_in  [NS];
  logic [TAG_W-1:0] tag_in  [NS];
  logic [SW-1:0]    rem_nxt [NS][LANES];
  logic [QW-1:0]    q_nxt   [NS][LANES];
  logic [SW-1:0]    rem_r   [NS][LANES];
  logic [QW-1:0]    q_r     [NS][LANES];
  logic [SW-1:0]    den_r   [NS];
  logic [TAG_W-1:0] tag_r   [NS];

  assign num[0] = in_num1;
  assign num[1] = in_num2;

  assign rdy[NS-1] = !v_r[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign v_in[j]   = in_valid;
      assign den_in[j] = in_den;
      assign tag_in[j] = in_tag;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[j][l] = SW'(num[l] >> 1);
        assign bit_in[j][l] = num[l][0];
        assign q_in[j][l]   = '0;
      end
    end else begin : g_next
      assign v_in[j]   = v_r[j-1];
      assign den_in[j] = den_r[j-1];
      assign tag_in[j] = tag_r[j-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[j][l] = rem_r[j-1][l];
        assign bit_in[j][l] = 1'b0;
        assign q_in[j][l]   = q_r[j-1][l];
      end
    end
  end

  always_comb begin
    logic [SW:0] r2;
    logic        ge;
    r2 = '0;
    ge = 1'b0;
    for (int j = 0; j < NS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        r2 = {rem_in[j][l], bit_in[j][l]};
        ge = r2 >= {1'b0, den_in[j]};
        rem_nxt[j][l] = ge ? SW'(r2 - {1'b0, den_in[j]}) : r2[SW-1:0];
        q_nxt[j][l]   = {q_in[j][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int j = 0; j < NS; j++) begin
        if (rdy[j]) v_r[j] <= v_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (rdy[j]) begin
        den_r[j] <= den_in[j];
        tag_r[j] <= tag_in[j];
        for (int l = 0; l < LANES; l++) begin
          rem_r[j][l] <= rem_nxt[j][l];
          q_r[j][l]   <= q_nxt[j][l];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_q1    = q_r[NS-1][0];
  assign out_q2    = q_r[NS-1][1];
  assign out_tag   = tag_r[NS-1];

endmodule

@@ rtl/svpwm_cmp.sv @@
// ----------------------------------------------------------------------------
// svpwm_cmp
// three-stage back end: phase on-times per sector, scaling by period plus one,
// saturation to the period and the output register
// ----------------------------------------------------------------------------
module svpwm_cmp #(
  parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [svpwm_pkg::PERIOD_W-1:0]    reload,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  svpwm_pkg::sector_t                in_sec,
  input  logic                              in_over,
  input  logic [FRAC_BITS-1:0]              in_t0h,
  input  logic [FRAC_BITS+1:0]              in_t1,
  input  logic [FRAC_BITS+1:0]              in_t2,
  input  logic [FRAC_BITS:0]                in_q1,
  input  logic [FRAC_BITS:0]                in_q2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output svpwm_pkg::sector_t                out_sector,
  output logic [svpwm_pkg::PERIOD_W-1:0]    out_compare_a,
  output logic [svpwm_pkg::PERIOD_W-1:0]    out_compare_b,
  output logic [svpwm_pkg::PERIOD_W-1:0]    out_compare_c,
  output logic                              out_overmodulated
);
  import svpwm_pkg::*;

  localparam int OW    = FRAC_BITS + 1;
  localparam int PW    = OW + PERIOD_W + 1;
  localparam int CW    = PW - FRAC_BITS;
  localparam int NS    = 3;
  localparam int PH    = 3;
  localparam logic [OW-1:0] HALF = OW'(64'd1 << (FRAC_BITS - 1));

  logic [NS-1:0]         v_r;
  logic [NS-1:0]         rdy;
  logic [OW-1:0]         tt1, tt2, h;
  logic [OW-1:0]         on_nxt  [PH];
  logic [OW-1:0]         on_r    [PH];
  logic [PW-1:0]         prod_r  [PH];
  logic [CW-1:0]         c_full  [PH];
  logic [PERIOD_W-1:0]   cmp_r   [PH];
  logic [PERIOD_W:0]     pp;
  sector_t               sec0_r, sec1_r, sec2_r;
  logic                  over0_r, over1_r, over2_r;

  assign rdy[NS-1] = !v_r[NS-1] || !out_stall;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign tt1 = in_over ? in_q1 : in_t1[OW-1:0];
  assign tt2 = in_over ? in_q2 : in_t2[OW-1:0];
  assign h   = OW'(in_t0h);

  always_comb begin
    on_nxt[0] = HALF;
    on_nxt[1] = HALF;
    on_nxt[2] = HALF;
    unique case (in_sec)
      SEC_1: begin
        on_nxt[0] = tt1 + tt2 + h;
        on_nxt[1] = tt2 + h;
        on_nxt[2] = h;
      end
      SEC_2: begin
        on_nxt[0] = tt1 + h;
        on_nxt[1] = tt1 + tt2 + h;
        on_nxt[2] = h;
      end
      SEC_3: begin
        on_nxt[0] = h;
        on_nxt[1] = tt1 + tt2 + h;
        on_nxt[2] = tt2 + h;
      end
      SEC_4: begin
        on_nxt[0] = h;
        on_nxt[1] = tt1 + h;
        on_nxt[2] = tt1 + tt2 + h;
      end
      SEC_5: begin
        on_nxt[0] = tt2 + h;
        on_nxt[1] = h;
        on_nxt[2] = tt1 + tt2 + h;
      end
      SEC_6: begin
        on_nxt[0] = tt1 + tt2 + h;
        on_nxt[1] = h;
        on_nxt[2] = tt1 + h;
      end
      default: begin
        on_nxt[0] = HALF;
        on_nxt[1] = HALF;
        on_nxt[2] = HALF;
      end
    endcase
  end

  assign pp = {1'b0, reload} + (PERIOD_W+1)'(1);

  for (genvar i = 0; i < PH; i++) begin : g_full
    assign c_full[i] = prod_r[i][PW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sec0_r  <= in_sec;
      over0_r <= in_over;
      for (int i = 0; i < PH; i++) on_r[i] <= on_nxt[i];
    end
    if (rdy[1]) begin
      sec1_r  <= sec0_r;
      over1_r <= over0_r;
      for (int i = 0; i < PH; i++) prod_r[i] <= PW'(on_r[i]) * PW'(pp);
    end
    if (rdy[2]) begin
      sec2_r  <= sec1_r;
      over2_r <= over1_r;
      for (int i = 0; i < PH; i++) begin
        cmp_r[i] <= (c_full[i] > CW'(reload)) ? reload : c_full[i][PERIOD_W-1:0];
      end
    end
  end

  assign in_ready          = rdy[0];
  assign out_valid         = v_r[NS-1];
  assign out_sector        = sec2_r;
  assign out_compare_a     = cmp_r[0];
  assign out_compare_b     = cmp_r[1];
  assign out_compare_c     = cmp_r[2];
  assign out_overmodulated = over2_r;

endmodule

@@ rtl/svpwm_sector_duty_calc.sv @@
// ----------------------------------------------------------------------------
// svpwm_sector_duty_calc
// six-sector space vector pwm: alpha/beta voltage in, sector and three
// centre-aligned compare values out, with overmodulation rescaling
//
//   channel | ports                                   | beat taken when
//   --------+-----------------------------------------+---------------------
//   in      | in_alpha_voltage, in_beta_voltage       | in_valid & !in_stall
//   out     | out_sector, out_compare_a/b/c,          | out_valid & !out_stall
//           | out_overmodulated                       |
//   cfg     | cfg_wr_data (timer reload)              | cfg_wr_en
//
// one beat per cycle sustained while out_stall stays low; the divider
// resolves one quotient bit per stage
// reset clears every stage valid bit and loads the timer reload with 999
// an output stall holds the result; empty stages upstream keep filling and
// in_stall rises only once every stage holds a beat
// ----------------------------------------------------------------------------
module svpwm_sector_duty_calc #(
  parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [svpwm_pkg::PERIOD_W-1:0]      cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [svpwm_pkg::VOLT_W-1:0] in_alpha_voltage,
  input  logic signed [svpwm_pkg::VOLT_W-1:0] in_beta_voltage,
  output logic                                out_valid,
  input  logic                                out_stall,
  output svpwm_pkg::sector_t                  out_sector,
  output logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_a,
  output logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_b,
  output logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_c,
  output logic                                out_overmodulated
);
  import svpwm_pkg::*;

  localparam int TW    = FRAC_BITS + 2;
  localparam int SW    = FRAC_BITS + 3;
  localparam int QW    = FRAC_BITS + 1;
  localparam int TAG_W = SECTOR_W + 1 + FRAC_BITS + 2 * TW;

  logic [PERIOD_W-1:0]  reload_r;

  logic                 tc_in_ready;
  logic                 tc_valid, tc_ready;
  sector_t              tc_sec;
  logic                 tc_over;
  logic [FRAC_BITS-1:0] tc_t0h;
  logic [TW-1:0]        tc_t1, tc_t2;
  logic [SW-1:0]        tc_sum;

  logic                 dv_valid, dv_ready;
  logic [QW-1:0]        dv_q1, dv_q2;
  logic [TAG_W-1:0]     dv_tag;
  sector_t              dv_sec;
  logic                 dv_over;
  logic [FRAC_BITS-1:0] dv_t0h;
  logic [TW-1:0]        dv_t1, dv_t2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= PERIOD_RST;
    end else if (cfg_wr_en) begin
      reload_r <= cfg_wr_data;
    end
  end

  assign in_stall = !tc_in_ready;

  svpwm_tcalc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_tcalc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (tc_in_ready),
    .in_alpha  (in_alpha_voltage),
    .in_beta   (in_beta_voltage),
    .out_valid (tc_valid),
    .out_ready (tc_ready),
    .out_sec   (tc_sec),
    .out_over  (tc_over),
    .out_t0h   (tc_t0h),
    .out_t1    (tc_t1),
    .out_t2    (tc_t2),
    .out_sum   (tc_sum)
  );

  svpwm_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tc_valid),
    .in_ready  (tc_ready),
    .in_num1   (tc_t1),
    .in_num2   (tc_t2),
    .in_den    (tc_sum),
    .in_tag    ({tc_sec, tc_over, tc_t0h, tc_t1, tc_t2}),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_q1    (dv_q1),
    .out_q2    (dv_q2),
    .out_tag   (dv_tag)
  );

  assign {dv_sec, dv_over, dv_t0h, dv_t1, dv_t2} = dv_tag;

  svpwm_cmp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cmp (
    .clk               (clk),
    .rst_n             (rst_n),
    .reload            (reload_r),
    .in_valid          (dv_valid),
    .in_ready          (dv_ready),
    .in_sec            (dv_sec),
    .in_over           (dv_over),
    .in_t0h            (dv_t0h),
    .in_t1             (dv_t1),
    .in_t2             (dv_t2),
    .in_q1             (dv_q1),
    .in_q2             (dv_q2),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sector        (out_sector),
    .out_compare_a     (out_compare_a),
    .out_compare_b     (out_compare_b),
    .out_compare_c     (out_compare_c),
    .out_overmodulated (out_overmodulated)
  );

endmodule

@@ rtl/svpwm_sva.sv @@
// ----------------------------------------------------------------------------
// svpwm_sva
// port-level checks for the space vector pwm duty calculator, bound to the
// top level
// ----------------------------------------------------------------------------
module svpwm_sva (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_wr_en,
  input logic [svpwm_pkg::PERIOD_W-1:0]      cfg_wr_data,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [svpwm_pkg::VOLT_W-1:0] in_alpha_voltage,
  input logic signed [svpwm_pkg::VOLT_W-1:0] in_beta_voltage,
  input logic                                out_valid,
  input logic                                out_stall,
  input svpwm_pkg::sector_t                  out_sector,
  input logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_a,
  input logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_b,
  input logic [svpwm_pkg::PERIOD_W-1:0]      out_compare_c,
  input logic                                out_overmodulated
);
  import svpwm_pkg::*;

  logic [PERIOD_W-1:0] period_q;

  // shadow of the period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_q <= PERIOD_RST;
    end else if (cfg_wr_en) begin
      period_q <= cfg_wr_data;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("pipeline not empty after reset");

  a_cmp_le_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compare_a <= period_q) && (out_compare_b <= period_q) &&
                  (out_compare_c <= period_q))
    else $error("compare value above period");

  a_sector_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sector == SEC_NONE) |->
      !out_overmodulated && (out_compare_a == out_compare_b) &&
      (out_compare_b == out_compare_c))
    else $error("undetermined sector not at equal half duty");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sector <= SEC_6)
    else $error("sector code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sector) &&
      $stable(out_compare_a) && $stable(out_overmodulated))
    else $error("stalled result beat changed");

endmodule

bind svpwm_sector_duty_calc svpwm_sva u_svpwm_sva (.*);

@@ verif/svpwm_sector_duty_calc_tb.sv @@
// ----------------------------------------------------------------------------
// svpwm_sector_duty_calc_tb
// self-checking bench for the six-sector space vector duty calculator: sends
// alpha/beta beats with random gaps and output stalls, predicts sector,
// compare values and overmodulation in fixed point and checks every result
// beat in order, across several timer reload settings including the extremes
// ----------------------------------------------------------------------------
module svpwm_sector_duty_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svpwm_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int LATENCY    = FRAC + 8;
  localparam int CYCLE_MAX  = 200000;
  localparam int RAND_ITEMS = 160;
  localparam int N_PHASES   = 8;

  localparam longint SQ3_K   = longint'((SQ3_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  localparam longint SQ3H_K  = longint'((SQ3_Q30 + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
  localparam longint K3HALF  = longint'(3) << (FRAC - 1);
  localparam longint ONE_FX  = longint'(1) << FRAC;

  typedef struct {
    logic signed [VOLT_W-1:0] alpha;
    logic signed [VOLT_W-1:0] beta;
    sector_t                  sector;
    logic [PERIOD_W-1:0]      cmp_a;
    logic [PERIOD_W-1:0]      cmp_b;
    logic [PERIOD_W-1:0]      cmp_c;
    logic                     over;
  } duty_t;

  class duty_scoreboard;
    logic [PERIOD_W-1:0] period = PERIOD_RST;
    duty_t               duty_q[$];
    int                  errors = 0;

    function automatic logic [PERIOD_W-1:0] to_count(longint on_time);
      longint c;
      c = (on_time * (longint'(period) + 1)) >> FRAC;
      if (c > longint'(period)) c = longint'(period);
      return c[PERIOD_W-1:0];
    endfunction

    function automatic duty_t calc_duty(logic signed [VOLT_W-1:0] a_in,
                                        logic signed [VOLT_W-1:0] b_in);
      longint   a, b, x, y, z, s1, s2, t1, t2, t0h, tsum, ta, tb, tc;
      sector_t  sec;
      duty_t    d;
      a = a_in;
      b = b_in;
      x = SQ3_K * b;
      y = K3HALF * a + SQ3H_K * b;
      z = -K3HALF * a + SQ3H_K * b;
      // index bits: y negative, z negative, beta positive
      case ({y < 0, z < 0, b > 0})
        3'b001:  sec = SEC_2;
        3'b010:  sec = SEC_6;
        3'b011:  sec = SEC_1;
        3'b100:  sec = SEC_4;
        3'b101:  sec = SEC_3;
        3'b110:  sec = SEC_5;
        default: sec = SEC_NONE;
      endcase
      s1 = 0;
      s2 = 0;
      case (sec)
        SEC_1: begin s1 = y;  s2 = x;  end
        SEC_2: begin s1 = -z; s2 = y;  end
        SEC_3: begin s1 = x;  s2 = z;  end
        SEC_4: begin s1 = -y; s2 = -x; end
        SEC_5: begin s1 = z;  s2 = -y; end
        SEC_6: begin s1 = -x; s2 = -z; end
        default: ;
      endcase
      t1 = (s1 <= 0) ? 0 : (s1 >> 15);
      t2 = (s2 <= 0) ? 0 : (s2 >> 15);
      tsum = t1 + t2;
      d.over = 1'b0;
      if (tsum > ONE_FX) begin
        t1 = (t1 * ONE_FX) / tsum;
        t2 = (t2 * ONE_FX) / tsum;
        t0h = 0;
        d.over = 1'b1;
      end else begin
        t0h = (ONE_FX - tsum) >> 1;
      end
      case (sec)
        SEC_1: begin ta = t1 + t2 + t0h; tb = t2 + t0h;      tc = t0h;           end
        SEC_2: begin ta = t1 + t0h;      tb = t1 + t2 + t0h; tc = t0h;           end
        SEC_3: begin ta = t0h;           tb = t1 + t2 + t0h; tc = t2 + t0h;      end
        SEC_4: begin ta = t0h;           tb = t1 + t0h;      tc = t1 + t2 + t0h; end
        SEC_5: begin ta = t2 + t0h;      tb = t0h;           tc = t1 + t2 + t0h; end
        SEC_6: begin ta = t1 + t2 + t0h; tb = t0h;           tc = t1 + t0h;      end
        default: begin
          ta = ONE_FX >> 1;
          tb = ONE_FX >> 1;
          tc = ONE_FX >> 1;
        end
      endcase
      d.alpha  = a_in;
      d.beta   = b_in;
      d.sector = sec;
      d.cmp_a  = to_count(ta);
      d.cmp_b  = to_count(tb);
      d.cmp_c  = to_count(tc);
      return d;
    endfunction

    function void note_sample(logic signed [VOLT_W-1:0] a, logic signed [VOLT_W-1:0] b);
      duty_q.push_back(calc_duty(a, b));
    endfunction

    function int pending();
      return duty_q.size();
    endfunction

    function void check_result(sector_t sec, logic [PERIOD_W-1:0] ca,
                               logic [PERIOD_W-1:0] cb, logic [PERIOD_W-1:0] cc,
                               logic over);
      duty_t e;
      if (duty_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result beat sec=%0d a=%0d b=%0d c=%0d ovr=%0b",
                   $realtime, sec, ca, cb, cc, over);
        return;
      end
      e = duty_q.pop_front();
      if (sec !== e.sector || ca !== e.cmp_a || cb !== e.cmp_b || cc !== e.cmp_c ||
          over !== e.over) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch for alpha=%0d beta=%0d period=%0d", $realtime,
                   e.alpha, e.beta, period);
          $display("  expected sec=%0d a=%0d b=%0d c=%0d ovr=%0b",
                   e.sector, e.cmp_a, e.cmp_b, e.cmp_c, e.over);
          $display("  actual   sec=%0d a=%0d b=%0d c=%0d ovr=%0b",
                   sec, ca, cb, cc, over);
        end
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [PERIOD_W-1:0]        cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [VOLT_W-1:0]   in_alpha_voltage = '0;
  logic signed [VOLT_W-1:0]   in_beta_voltage = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  sector_t                    out_sector;
  logic [PERIOD_W-1:0]        out_compare_a;
  logic [PERIOD_W-1:0]        out_compare_b;
  logic [PERIOD_W-1:0]        out_compare_c;
  logic                       out_overmodulated;

  duty_scoreboard sb = new;
  bit             idle_on = 1'b1;
  int             cycle_count = 0;
  int             stall_left = 0;

  svpwm_sector_duty_calc #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_alpha_voltage (in_alpha_voltage),
    .in_beta_voltage  (in_beta_voltage),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sector       (out_sector),
    .out_compare_a    (out_compare_a),
    .out_compare_b    (out_compare_b),
    .out_compare_c    (out_compare_c),
    .out_overmodulated(out_overmodulated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_sector, out_compare_a, out_compare_b, out_compare_c,
                      out_overmodulated);
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 2));
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_sample(input logic signed [VOLT_W-1:0] a,
                             input logic signed [VOLT_W-1:0] b);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_alpha_voltage <= a;
    in_beta_voltage  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_sample(a, b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.period = value;
  endtask

  task automatic run_directed();
    // origin, full-scale corners, unit steps, sector centers, exact line hits
    int da [24] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, -1, 0,
                    0, 20000, 0, -20000, -20000, 0, 20000, -14189, 14189, 14189,
                    -14189, 12000};
    int db [24] = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0, 0, 1,
                    -1, 11547, 23094, 11547, -11547, -23094, -11547, 24576, 24576,
                    -24576, -24576, 6928};
    for (int i = 0; i < 24; i++)
      send_sample(VOLT_W'(da[i]), VOLT_W'(db[i]));
  endtask

  task automatic pick_sample(output logic signed [VOLT_W-1:0] a,
                             output logic signed [VOLT_W-1:0] b);
    int sel;
    int ja;
    int jb;
    sel = $urandom_range(0, 3);
    ja  = int'($urandom_range(0, 4)) - 2;
    jb  = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = VOLT_W'($urandom);
        b = VOLT_W'($urandom);
      end
      3, 4, 5: begin
        a = $signed(VOLT_W'($urandom)) >>> $urandom_range(1, 14);
        b = $signed(VOLT_W'($urandom)) >>> $urandom_range(1, 14);
      end
      6: begin
        a = (sel == 0) ? '0 : VOLT_W'($urandom);
        b = (sel == 1) ? '0 : VOLT_W'($urandom);
        if (sel == 2) begin
          a = '0;
          b = '0;
        end
      end
      7: begin
        // close to a reference line
        a = VOLT_W'((sel[0] ? 14189 : -14189) + ja);
        b = VOLT_W'((sel[1] ? 24576 : -24576) + jb);
      end
      default: begin
        a = VOLT_W'(int'($urandom_range(0, 36000)) - 18000);
        b = VOLT_W'(int'($urandom_range(0, 36000)) - 18000);
      end
    endcase
  endtask

  initial begin
    int unsigned plan [N_PHASES] = '{65535, 0, 1, 2, 0, 0, 999, 65534};
    logic signed [VOLT_W-1:0] a;
    logic signed [VOLT_W-1:0] b;
    logic [PERIOD_W-1:0] per;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      per = (ph == 4 || ph == 5) ? PERIOD_W'($urandom_range(3, 65533)) : PERIOD_W'(plan[ph]);
      write_period(per);
      idle_on = (ph != N_PHASES - 1);
      run_directed();
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (i % 32 == 0 && ph != N_PHASES - 1)
          idle_on = ($urandom_range(0, 3) != 0);
        pick_sample(a, b);
        send_sample(a, b);
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
